@@ hdl/snlp_pkg.sv @@
// shared types, character codes and radix codes of the number literal parser
`default_nettype none
package snlp_pkg;

  // depth of the queue between front and back
  localparam int SNLP_QUEUE_DEPTH = 2;

  // radix codes
  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_BIN = 2'd1;
  localparam logic [1:0] RADIX_OCT = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  // ascii character codes
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0d;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_QUESTION   = 8'h3f;
  localparam logic [7:0] CH_QUOTE      = 8'h27;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_LO_A       = 8'h61;
  localparam logic [7:0] CH_LO_F       = 8'h66;
  localparam logic [7:0] CH_UP_A       = 8'h41;
  localparam logic [7:0] CH_UP_F       = 8'h46;
  localparam logic [7:0] CH_LO_B       = 8'h62;
  localparam logic [7:0] CH_UP_B       = 8'h42;
  localparam logic [7:0] CH_LO_O       = 8'h6f;
  localparam logic [7:0] CH_UP_O       = 8'h4f;
  localparam logic [7:0] CH_LO_D       = 8'h64;
  localparam logic [7:0] CH_UP_D       = 8'h44;
  localparam logic [7:0] CH_LO_H       = 8'h68;
  localparam logic [7:0] CH_UP_H       = 8'h48;
  localparam logic [7:0] CH_LO_S       = 8'h73;
  localparam logic [7:0] CH_UP_S       = 8'h53;
  localparam logic [7:0] CH_LO_X       = 8'h78;
  localparam logic [7:0] CH_UP_X       = 8'h58;
  localparam logic [7:0] CH_LO_Z       = 8'h7a;
  localparam logic [7:0] CH_UP_Z       = 8'h5a;

  // one classified character
  typedef struct packed {
    logic       is_space;
    logic       is_digit;
    logic       is_hexdig;
    logic       is_unknown;
    logic       is_under;
    logic       is_quote;
    logic       is_sign;
    logic       is_base;
    logic [1:0] radix;
    logic [3:0] value;
    logic       last;
  } snlp_item_t;

  // queue occupancy seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } snlp_q_status_t;

endpackage : snlp_pkg
`default_nettype wire

@@ hdl/snlp_front.sv @@
// front stage: accepts characters and classifies them into queue items
`default_nettype none
module snlp_front (
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [7:0]              in_char_code,
  input  wire logic                    in_final_char,
  input  wire snlp_pkg::snlp_q_status_t q_status,
  output logic                         push,
  output snlp_pkg::snlp_item_t         push_item
);
  import snlp_pkg::*;

  logic [7:0] c;
  logic       lo_hex;
  logic       up_hex;

  assign c = in_char_code;

  // transfer into the queue whenever it has room
  assign in_ready = !q_status.full;
  assign push     = in_valid && !q_status.full;

  // character classification
  always_comb begin
    lo_hex = (c >= CH_LO_A) && (c <= CH_LO_F);
    up_hex = (c >= CH_UP_A) && (c <= CH_UP_F);
    push_item            = '0;
    push_item.is_space   = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    push_item.is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
    push_item.is_hexdig  = push_item.is_digit || lo_hex || up_hex;
    push_item.is_unknown = (c == CH_LO_X) || (c == CH_UP_X) || (c == CH_LO_Z) ||
                           (c == CH_UP_Z) || (c == CH_QUESTION);
    push_item.is_under   = (c == CH_UNDERSCORE);
    push_item.is_quote   = (c == CH_QUOTE);
    push_item.is_sign    = (c == CH_LO_S) || (c == CH_UP_S);
    push_item.last       = in_final_char;

    // digit value, zero for unknown digits
    if (push_item.is_digit) begin
      push_item.value = 4'(c - CH_ZERO);
    end else if (lo_hex) begin
      push_item.value = 4'(c - CH_LO_A + 8'd10);
    end else if (up_hex) begin
      push_item.value = 4'(c - CH_UP_A + 8'd10);
    end

    // base letters
    if ((c == CH_LO_B) || (c == CH_UP_B)) begin
      push_item.is_base = 1'b1;
      push_item.radix   = RADIX_BIN;
    end else if ((c == CH_LO_O) || (c == CH_UP_O)) begin
      push_item.is_base = 1'b1;
      push_item.radix   = RADIX_OCT;
    end else if ((c == CH_LO_D) || (c == CH_UP_D)) begin
      push_item.is_base = 1'b1;
      push_item.radix   = RADIX_DEC;
    end else if ((c == CH_LO_H) || (c == CH_UP_H)) begin
      push_item.is_base = 1'b1;
      push_item.radix   = RADIX_HEX;
    end
  end

endmodule : snlp_front
`default_nettype wire

@@ hdl/snlp_queue.sv @@
// small fifo of classified characters between front and back
`default_nettype none
module snlp_queue #(
  parameter int DEPTH = snlp_pkg::SNLP_QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire snlp_pkg::snlp_item_t push_item,
  input  wire logic                 pop,
  output snlp_pkg::snlp_item_t      pop_item,
  output logic                      pop_valid,
  output snlp_pkg::snlp_q_status_t  status
);
  import snlp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  snlp_item_t    mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign status.full  = (count_r == CW'(DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_valid    = !status.empty;
  assign pop_item     = mem_r[rd_ptr_r];

  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule : snlp_queue
`default_nettype wire

@@ hdl/snlp_exec.sv @@
// back stage: literal state machine, accumulator and result register
`default_nettype none
module snlp_exec (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire snlp_pkg::snlp_item_t item,
  input  wire logic                 item_valid,
  output logic                      item_pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_parse_ok,
  output logic [63:0]               out_low_bits,
  output logic                      out_value_fits
);
  import snlp_pkg::*;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIZE,
    PH_PAD,
    PH_QUOTE,
    PH_SIGN,
    PH_DIGITS,
    PH_ERROR
  } phase_t;

  phase_t      phase_r, phase_nxt, phase_cur;
  logic [63:0] acc_r, acc_nxt;
  logic        fits_r, fits_nxt;
  logic [1:0]  radix_r, radix_nxt;
  logic        pend_r, pend_nxt;
  logic        size_seen_r, size_seen_nxt;
  logic        dig_seen_r, dig_seen_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        ok_r, ok_nxt;
  logic [63:0] low_r, low_nxt;
  logic        ofits_r, ofits_nxt;

  logic [67:0] dec_sum;
  logic        dec_ovf;
  logic [63:0] shl_acc;
  logic        shl_ovf;
  logic        digit_legal;
  logic        ok_now;

  // a final character needs the result register free
  assign item_pop = item_valid && (!item.last || !out_valid_r || out_ready);

  // times-ten add with carry-out check
  assign dec_sum = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + {64'd0, item.value};
  assign dec_ovf = |dec_sum[67:64];

  // based digit shift-in and legality
  always_comb begin
    case (radix_r)
      RADIX_BIN: begin
        shl_acc     = {acc_r[62:0], item.value[0]};
        shl_ovf     = acc_r[63];
        digit_legal = (item.is_hexdig || item.is_unknown) && (item.value < 4'd2);
      end
      RADIX_OCT: begin
        shl_acc     = {acc_r[60:0], item.value[2:0]};
        shl_ovf     = |acc_r[63:61];
        digit_legal = (item.is_hexdig || item.is_unknown) && (item.value < 4'd8);
      end
      RADIX_HEX: begin
        shl_acc     = {acc_r[59:0], item.value};
        shl_ovf     = |acc_r[63:60];
        digit_legal = item.is_hexdig || item.is_unknown;
      end
      default: begin
        shl_acc     = dec_sum[63:0];
        shl_ovf     = dec_ovf;
        digit_legal = item.is_digit && !item.is_unknown;
      end
    endcase
  end

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    acc_nxt       = acc_r;
    fits_nxt      = fits_r;
    radix_nxt     = radix_r;
    pend_nxt      = pend_r;
    size_seen_nxt = size_seen_r;
    dig_seen_nxt  = dig_seen_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ok_nxt        = ok_r;
    low_nxt       = low_r;
    ofits_nxt     = ofits_r;
    phase_cur     = (phase_r == PH_LEAD) ? PH_SIZE : phase_r;
    ok_now        = 1'b0;

    if (item_pop) begin
      if (phase_r != PH_ERROR) begin
        if (item.is_space) begin
          if (phase_r != PH_LEAD) begin
            pend_nxt = 1'b1;
          end
        end else begin
          phase_nxt = phase_cur;
          case (phase_cur)
            PH_SIZE: begin
              if (item.is_under) begin
                if (pend_r) begin
                  phase_nxt = size_seen_r ? PH_PAD : PH_ERROR;
                end
              end else if (item.is_digit) begin
                if (pend_r) begin
                  phase_nxt = PH_ERROR;
                end else begin
                  size_seen_nxt = 1'b1;
                  acc_nxt       = dec_sum[63:0];
                  fits_nxt      = fits_r && !dec_ovf;
                end
              end else if (item.is_quote) begin
                if (pend_r && !size_seen_r) begin
                  phase_nxt = PH_ERROR;
                end else begin
                  phase_nxt = PH_QUOTE;
                  pend_nxt  = 1'b0;
                  acc_nxt   = '0;
                  fits_nxt  = 1'b1;
                end
              end else begin
                phase_nxt = PH_ERROR;
              end
            end
            PH_PAD: begin
              if (item.is_quote) begin
                phase_nxt = PH_QUOTE;
                pend_nxt  = 1'b0;
                acc_nxt   = '0;
                fits_nxt  = 1'b1;
              end else if (!item.is_under) begin
                phase_nxt = PH_ERROR;
              end
            end
            PH_QUOTE, PH_SIGN: begin
              if (pend_r) begin
                phase_nxt = PH_ERROR;
              end else if (item.is_under) begin
                phase_nxt = phase_cur;
              end else if ((phase_cur == PH_QUOTE) && item.is_sign) begin
                phase_nxt = PH_SIGN;
              end else if (item.is_base) begin
                phase_nxt = PH_DIGITS;
                radix_nxt = item.radix;
              end else begin
                phase_nxt = PH_ERROR;
              end
            end
            PH_DIGITS: begin
              if (pend_r) begin
                phase_nxt = PH_ERROR;
              end else if (item.is_under) begin
                phase_nxt = PH_DIGITS;
              end else if (digit_legal) begin
                dig_seen_nxt = 1'b1;
                acc_nxt      = shl_acc;
                fits_nxt     = fits_r && !shl_ovf;
              end else begin
                phase_nxt = PH_ERROR;
              end
            end
            default: begin
              phase_nxt = PH_ERROR;
            end
          endcase
        end
      end

      // last character: load result and return to reset state
      if (item.last) begin
        ok_now = ((phase_nxt == PH_SIZE) && size_seen_nxt) ||
                 ((phase_nxt == PH_DIGITS) && dig_seen_nxt);
        out_valid_nxt = 1'b1;
        ok_nxt        = ok_now;
        low_nxt       = ok_now ? acc_nxt : '0;
        ofits_nxt     = ok_now && fits_nxt;
        phase_nxt     = PH_LEAD;
        acc_nxt       = '0;
        fits_nxt      = 1'b1;
        radix_nxt     = RADIX_DEC;
        pend_nxt      = 1'b0;
        size_seen_nxt = 1'b0;
        dig_seen_nxt  = 1'b0;
      end
    end
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD;
      acc_r       <= '0;
      fits_r      <= 1'b1;
      radix_r     <= RADIX_DEC;
      pend_r      <= 1'b0;
      size_seen_r <= 1'b0;
      dig_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      fits_r      <= fits_nxt;
      radix_r     <= radix_nxt;
      pend_r      <= pend_nxt;
      size_seen_r <= size_seen_nxt;
      dig_seen_r  <= dig_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ok_r    <= ok_nxt;
    low_r   <= low_nxt;
    ofits_r <= ofits_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_parse_ok   = ok_r;
  assign out_low_bits   = low_r;
  assign out_value_fits = ofits_r;

endmodule : snlp_exec
`default_nettype wire

@@ hdl/sv_number_literal_parser_unit.sv @@
// top level of the number literal parser: front, queue and back
// Parses one number literal from a stream of ASCII characters, one character per
// transfer on the in_ channel, with in_final_char marking the last one. The block
// takes one character per clock cycle while the queue is not full, and delivers one
// result on the out_ channel for each final character: parse_ok, the value modulo
// 2^64 and a flag that the exact value is below 2^64. A character is registered in
// the queue, then popped by the back stage into its accumulator or, for a final
// character, its result registers; the back stage does the times-ten add
// combinationally. A queue of QUEUE_DEPTH classified characters lets the input
// keep flowing while a finished result waits on out_ready.
`default_nettype none
module sv_number_literal_parser_unit #(
  parameter int QUEUE_DEPTH = snlp_pkg::SNLP_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_final_char,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_parse_ok,
  output logic [63:0]      out_low_bits,
  output logic             out_value_fits
);
  import snlp_pkg::*;

  snlp_item_t     push_item;
  snlp_item_t     pop_item;
  snlp_q_status_t q_status;
  logic           push;
  logic           pop;
  logic           pop_valid;

  // classify incoming characters
  snlp_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_char_code  (in_char_code),
    .in_final_char (in_final_char),
    .q_status      (q_status),
    .push          (push),
    .push_item     (push_item)
  );

  // decoupling queue
  snlp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .pop_valid (pop_valid),
    .status    (q_status)
  );

  // parse and accumulate
  snlp_exec u_exec (
    .clk            (clk),
    .rst_n          (rst_n),
    .item           (pop_item),
    .item_valid     (pop_valid),
    .item_pop       (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_parse_ok   (out_parse_ok),
    .out_low_bits   (out_low_bits),
    .out_value_fits (out_value_fits)
  );

`ifndef SYNTHESIS
  // a value can only fit when the literal was accepted
  a_fits_needs_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_value_fits || out_parse_ok))
    else $error("value_fits set on a rejected literal");

  // a rejected literal reports zero
  a_reject_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_parse_ok) |-> (out_low_bits == 64'd0))
    else $error("rejected literal carries a nonzero value");

  // queue never reports full and empty together
  a_queue_status : assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("queue full and empty at once");

  // back stage never pops an empty queue
  a_no_empty_pop : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");
`endif

endmodule : sv_number_literal_parser_unit
`default_nettype wire
